// ===== rtl/sbpc_pkg.sv =====
package sbpc_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] LEN_WORD    = 8'd5;
  localparam logic [7:0] LEN_SHORT   = 8'd4;
  localparam logic [7:0] INSTR_WRITE = 8'd3;
  localparam logic [7:0] INSTR_READ  = 8'd2;
  localparam logic [7:0] READ_COUNT  = 8'd2;
  localparam logic [7:0] MIN_LEN     = 8'd2;

  typedef enum logic [1:0] {
    KIND_WRITE_WORD = 2'd0,
    KIND_WRITE_BYTE = 2'd1,
    KIND_READ_WORD  = 2'd2,
    KIND_RX_BYTE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_ID     = 3'd2,
    PH_LEN    = 3'd3,
    PH_ERROR  = 3'd4,
    PH_PARAM  = 3'd5,
    PH_CSUM   = 3'd6
  } phase_e;

  // Framer status toward the top level
  typedef struct packed {
    logic       busy;
    logic [7:0] tx_byte;
    logic       tx_last;
  } frm_t;

  // Parser report for one completed status packet
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [7:0]  error;
    logic [15:0] value;
  } status_t;

  // One result word
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        status_done;
    logic        status_ok;
    logic [7:0]  status_error;
    logic [15:0] status_value;
  } out_word_t;

endpackage

// ===== rtl/sbpc_framer.sv =====
module sbpc_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  sbpc_pkg::kind_e     kind_i,
  input  logic [7:0]          servo_id_i,
  input  logic [7:0]          reg_address_i,
  input  logic [15:0]         write_value_i,
  input  logic                advance_i,
  output sbpc_pkg::frm_t      frm_o
);

  logic            busy_q, busy_d;
  logic [3:0]      idx_q, idx_d;
  sbpc_pkg::kind_e kind_q;
  logic [7:0]      id_q;
  logic [7:0]      addr_q;
  logic [15:0]     val_q;

  logic       is_word;
  logic       is_read;
  logic [7:0] len_b;
  logic [7:0] instr_b;
  logic [7:0] p0_b;
  logic [7:0] p1_b;
  logic [7:0] csum_b;
  logic [3:0] last_idx;
  logic [7:0] byte_sel;
  logic       last_sel;

  always_comb begin
    is_word  = (kind_q == sbpc_pkg::KIND_WRITE_WORD);
    is_read  = (kind_q == sbpc_pkg::KIND_READ_WORD);
    len_b    = is_word ? sbpc_pkg::LEN_WORD : sbpc_pkg::LEN_SHORT;
    instr_b  = is_read ? sbpc_pkg::INSTR_READ : sbpc_pkg::INSTR_WRITE;
    p0_b     = is_read ? sbpc_pkg::READ_COUNT : val_q[7:0];
    p1_b     = is_word ? val_q[15:8] : 8'd0;
    csum_b   = ~(id_q + len_b + instr_b + addr_q + p0_b + p1_b);
    last_idx = is_word ? 4'd8 : 4'd7;
    case (idx_q)
      4'd0, 4'd1: byte_sel = sbpc_pkg::HDR_BYTE;
      4'd2:       byte_sel = id_q;
      4'd3:       byte_sel = len_b;
      4'd4:       byte_sel = instr_b;
      4'd5:       byte_sel = addr_q;
      4'd6:       byte_sel = p0_b;
      4'd7:       byte_sel = is_word ? p1_b : csum_b;
      default:    byte_sel = csum_b;
    endcase
    last_sel = (idx_q == last_idx);
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = 4'd0;
    end else if (busy_q && advance_i) begin
      idx_d = idx_q + 4'd1;
      if (last_sel) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_i;
      id_q   <= servo_id_i;
      addr_q <= reg_address_i;
      val_q  <= write_value_i;
    end
  end

  assign frm_o.busy    = busy_q;
  assign frm_o.tx_byte = byte_sel;
  assign frm_o.tx_last = last_sel;

endmodule

// ===== rtl/sbpc_parser.sv =====
module sbpc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_byte_i,
  output sbpc_pkg::status_t  status_o
);

  sbpc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  err_q, err_d;
  logic [15:0] val_q, val_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  expected;

  assign expected = (len_q < sbpc_pkg::MIN_LEN) ? 8'd0 : len_q - sbpc_pkg::MIN_LEN;

  // Next state
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    len_d   = len_q;
    err_d   = err_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      unique case (phase_q)
        sbpc_pkg::PH_HDR0: begin
          if (rx_byte_i == sbpc_pkg::HDR_BYTE) begin
            phase_d = sbpc_pkg::PH_HDR1;
          end
        end
        sbpc_pkg::PH_HDR1: begin
          phase_d = (rx_byte_i == sbpc_pkg::HDR_BYTE) ? sbpc_pkg::PH_ID : sbpc_pkg::PH_HDR0;
        end
        sbpc_pkg::PH_ID: begin
          sum_d   = rx_byte_i;
          val_d   = 16'd0;
          cnt_d   = 8'd0;
          err_d   = 8'd0;
          phase_d = sbpc_pkg::PH_LEN;
        end
        sbpc_pkg::PH_LEN: begin
          len_d   = rx_byte_i;
          sum_d   = sum_q + rx_byte_i;
          phase_d = sbpc_pkg::PH_ERROR;
        end
        sbpc_pkg::PH_ERROR: begin
          err_d   = rx_byte_i;
          sum_d   = sum_q + rx_byte_i;
          phase_d = (expected != 8'd0) ? sbpc_pkg::PH_PARAM : sbpc_pkg::PH_CSUM;
        end
        sbpc_pkg::PH_PARAM: begin
          sum_d = sum_q + rx_byte_i;
          if (cnt_q == 8'd0) begin
            val_d = {val_q[15:8], rx_byte_i};
          end else if (cnt_q == 8'd1) begin
            val_d = {rx_byte_i, val_q[7:0]};
          end
          cnt_d = cnt_q + 8'd1;
          if (cnt_d >= expected) begin
            phase_d = sbpc_pkg::PH_CSUM;
          end
        end
        sbpc_pkg::PH_CSUM: begin
          phase_d = sbpc_pkg::PH_HDR0;
        end
        default: begin
          phase_d = sbpc_pkg::PH_HDR0;
        end
      endcase
    end
  end

  // Report
  always_comb begin
    status_o.done  = step_i && (phase_q == sbpc_pkg::PH_CSUM);
    status_o.ok    = (~sum_q == rx_byte_i) && (err_q == 8'd0);
    status_o.error = err_q;
    status_o.value = val_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sbpc_pkg::PH_HDR0;
      sum_q   <= 8'd0;
      len_q   <= 8'd0;
      err_q   <= 8'd0;
      val_q   <= 16'd0;
      cnt_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      err_q   <= err_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/servo_bus_packet_codec_top.sv =====
// Channel | Dir | tdata (low bit up)                              | tuser / tlast
// s_axis  | in  | servo_id, reg_address, write_value, rx_byte      | tuser: kind
// m_axis  | out | tx_byte, status_ok, status_error, status_value  | tuser: tx_valid,
//         |     |                                                 | status_done; tlast: tx_last
//
// A received line byte steps the parser; back-to-back line bytes flow at one word per clock
// while the framer is idle and the output is not stalled. A command word loads the framer,
// which then emits 8 or 9 packet bytes at one per cycle while the output takes them. The
// input stage holds the next word until the framer has handed its last byte to the result
// register. Reset clears the parser to wait for a header and empties the input stage,
// framer and output register. Output stalls hold the result register and stop line bytes;
// the input stage still takes one word meanwhile.
module servo_bus_packet_codec_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // servo_id[7:0], reg_address[15:8],
                                       // write_value[31:16], rx_byte[39:32]
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // tx_byte[7:0], status_ok[8], status_error[16:9],
                                       // status_value[32:17], zero[39:33]
  output logic [1:0]  m_axis_tuser_o,  // tx_valid[0], status_done[1]
  output logic        m_axis_tlast_o   // tx_last
);

  // Input stage
  logic            in_valid_q, in_valid_d;
  sbpc_pkg::kind_e in_kind_q;
  logic [7:0]      in_id_q;
  logic [7:0]      in_addr_q;
  logic [15:0]     in_val_q;
  logic [7:0]      in_rx_q;

  // Output register
  logic                m_valid_q, m_valid_d;
  sbpc_pkg::out_word_t m_word_q, m_word_d;

  sbpc_pkg::frm_t    frm;
  sbpc_pkg::status_t status;

  logic out_free;
  logic in_go;
  logic is_rx;
  logic frm_load;
  logic parse_step;
  logic s_take;

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign is_rx      = (in_kind_q == sbpc_pkg::KIND_RX_BYTE);
  // Commands go to the idle framer; line bytes also wait for it and need a free output slot for a possible report
  assign in_go      = in_valid_q && !frm.busy && (!is_rx || out_free);
  assign frm_load   = in_go && !is_rx;
  assign parse_step = in_go && is_rx;

  assign s_axis_tready_o = !in_valid_q || in_go;
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;

  sbpc_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (frm_load),
    .kind_i        (in_kind_q),
    .servo_id_i    (in_id_q),
    .reg_address_i (in_addr_q),
    .write_value_i (in_val_q),
    .advance_i     (out_free),
    .frm_o         (frm)
  );

  sbpc_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (parse_step),
    .rx_byte_i (in_rx_q),
    .status_o  (status)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_take) begin
      in_valid_d = 1'b1;
    end else if (in_go) begin
      in_valid_d = 1'b0;
    end
  end

  // Load the result register from the framer or from a finished status packet
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_word_d  = m_word_q;
    if (frm.busy && out_free) begin
      m_valid_d             = 1'b1;
      m_word_d              = '0;
      m_word_d.tx_valid     = 1'b1;
      m_word_d.tx_byte      = frm.tx_byte;
      m_word_d.tx_last      = frm.tx_last;
    end else if (status.done) begin
      m_valid_d             = 1'b1;
      m_word_d              = '0;
      m_word_d.status_done  = 1'b1;
      m_word_d.status_ok    = status.ok;
      m_word_d.status_error = status.error;
      m_word_d.status_value = status.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_kind_q <= sbpc_pkg::kind_e'(s_axis_tuser_i);
      in_id_q   <= s_axis_tdata_i[7:0];
      in_addr_q <= s_axis_tdata_i[15:8];
      in_val_q  <= s_axis_tdata_i[31:16];
      in_rx_q   <= s_axis_tdata_i[39:32];
    end
    m_word_q <= m_word_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_word_q.status_value, m_word_q.status_error,
                            m_word_q.status_ok, m_word_q.tx_byte};
  assign m_axis_tuser_o  = {m_word_q.status_done, m_word_q.tx_valid};
  assign m_axis_tlast_o  = m_word_q.tx_last;

endmodule

// ===== tb/sbpc_ledger_pkg.sv =====
`timescale 1ns / 1ps
package sbpc_ledger_pkg;
  import sbpc_pkg::*;

  // Predicts the packet bytes and status reports of the codec and holds them
  // until the output side delivers them.
  class codec_ledger;
    out_word_t   pending_words[$];
    int unsigned mismatches;

    // status packet parser copy
    phase_e      parse_phase;
    logic [7:0]  line_sum;
    logic [7:0]  line_len;
    logic [7:0]  line_error;
    logic [15:0] line_value;
    logic [7:0]  line_params;

    function new();
      mismatches  = 0;
      parse_phase = PH_HDR0;
      line_sum    = '0;
      line_len    = '0;
      line_error  = '0;
      line_value  = '0;
      line_params = '0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void push_tx(logic [7:0] b, logic last);
      out_word_t w;
      w = '0;
      w.tx_valid = 1'b1;
      w.tx_byte  = b;
      w.tx_last  = last;
      pending_words.push_back(w);
    endfunction

    // Header, body, then the inverted 8-bit sum of the body.
    function void frame_command(logic [7:0] body [6], int n);
      logic [7:0] sum;
      sum = '0;
      push_tx(HDR_BYTE, 1'b0);
      push_tx(HDR_BYTE, 1'b0);
      for (int i = 0; i < n; i++) begin
        sum += body[i];
        push_tx(body[i], 1'b0);
      end
      push_tx(~sum, 1'b1);
    endfunction

    function logic [7:0] params_due();
      return (line_len < MIN_LEN) ? 8'd0 : line_len - MIN_LEN;
    endfunction

    function void parse_line_byte(logic [7:0] b);
      out_word_t  w;
      logic [7:0] want;
      case (parse_phase)
        PH_HDR0: begin
          if (b == HDR_BYTE) parse_phase = PH_HDR1;
        end
        PH_HDR1: begin
          parse_phase = (b == HDR_BYTE) ? PH_ID : PH_HDR0;
        end
        PH_ID: begin
          line_sum    = b;
          line_value  = '0;
          line_params = '0;
          line_error  = '0;
          parse_phase = PH_LEN;
        end
        PH_LEN: begin
          line_len    = b;
          line_sum   += b;
          parse_phase = PH_ERROR;
        end
        PH_ERROR: begin
          line_error  = b;
          line_sum   += b;
          parse_phase = (params_due() != 8'd0) ? PH_PARAM : PH_CSUM;
        end
        PH_PARAM: begin
          line_sum += b;
          // only the first two parameters land in the value, low byte first
          if (line_params == 8'd0) line_value[7:0] = b;
          else if (line_params == 8'd1) line_value[15:8] = b;
          line_params++;
          if (line_params >= params_due()) parse_phase = PH_CSUM;
        end
        PH_CSUM: begin
          want           = ~line_sum;
          w              = '0;
          w.status_done  = 1'b1;
          w.status_ok    = (want == b) && (line_error == 8'd0);
          w.status_error = line_error;
          w.status_value = line_value;
          pending_words.push_back(w);
          parse_phase    = PH_HDR0;
        end
        default: parse_phase = PH_HDR0;
      endcase
    endfunction

    function void note_word(kind_e kind, logic [7:0] id, logic [7:0] addr,
                            logic [15:0] val, logic [7:0] rx);
      logic [7:0] body [6];
      case (kind)
        KIND_WRITE_WORD: begin
          body = '{id, LEN_WORD, INSTR_WRITE, addr, val[7:0], val[15:8]};
          frame_command(body, 6);
        end
        KIND_WRITE_BYTE: begin
          body = '{id, LEN_SHORT, INSTR_WRITE, addr, val[7:0], 8'd0};
          frame_command(body, 5);
        end
        KIND_READ_WORD: begin
          body = '{id, LEN_SHORT, INSTR_READ, addr, READ_COUNT, 8'd0};
          frame_command(body, 5);
        end
        default: parse_line_byte(rx);
      endcase
    endfunction

    task check_word(out_word_t got, logic [6:0] pad);
      out_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word tx %0b/%02h/%0b st %0b/%0b/%02h/%04h",
                                  got.tx_valid, got.tx_byte, got.tx_last, got.status_done,
                                  got.status_ok, got.status_error, got.status_value));
        return;
      end
      want = pending_words.pop_front();
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.tx_last !== want.tx_last || got.status_done !== want.status_done ||
          got.status_ok !== want.status_ok || got.status_error !== want.status_error ||
          got.status_value !== want.status_value || pad !== 7'd0) begin
        report_mismatch($sformatf(
          "tx %0b/%02h/%0b st %0b/%0b/%02h/%04h pad %02h, want tx %0b/%02h/%0b st %0b/%0b/%02h/%04h",
          got.tx_valid, got.tx_byte, got.tx_last, got.status_done, got.status_ok,
          got.status_error, got.status_value, pad, want.tx_valid, want.tx_byte,
          want.tx_last, want.status_done, want.status_ok, want.status_error,
          want.status_value));
      end
    endtask
  endclass

endpackage

// ===== tb/servo_bus_packet_codec_top_test.sv =====
`timescale 1ns / 1ps
module servo_bus_packet_codec_top_test;
  import sbpc_pkg::*;
  import sbpc_ledger_pkg::*;

  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  codec_ledger ledger = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;
  int unsigned cycle_count;

  servo_bus_packet_codec_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: check at the rising edge, change ready at the falling edge.
  initial begin
    out_word_t seen;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && m_tvalid && m_tready) begin
        seen              = '0;
        seen.tx_valid     = m_tuser[0];
        seen.tx_byte      = m_tdata[7:0];
        seen.tx_last      = m_tlast;
        seen.status_done  = m_tuser[1];
        seen.status_ok    = m_tdata[8];
        seen.status_error = m_tdata[16:9];
        seen.status_value = m_tdata[32:17];
        ledger.check_word(seen, m_tdata[39:33]);
      end
      @(negedge clk);
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word; idle first at random, then hold until it is taken.
  task automatic send_word(kind_e kind, logic [7:0] id, logic [7:0] addr,
                           logic [15:0] val, logic [7:0] rx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 40'({$urandom, $urandom});
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {rx, val, addr, id};
    do @(posedge clk); while (!s_tready);
    ledger.note_word(kind, id, addr, val, rx);
    words_sent++;
  endtask

  task automatic send_rx(logic [7:0] b);
    send_word(KIND_RX_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), b);
  endtask

  task automatic send_cmd(kind_e kind, logic [7:0] id, logic [7:0] addr, logic [15:0] val);
    send_word(kind, id, addr, val, 8'($urandom));
  endtask

  task automatic send_random_cmd();
    send_cmd(kind_e'($urandom_range(2)), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Feed one status packet; optionally break the checksum or slip a command
  // in between two of its bytes.
  task automatic send_status_packet(logic [7:0] id, logic [7:0] len, logic [7:0] err,
                                    bit good_sum, bit cut_in);
    logic [7:0] line [$];
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         cut_at;
    n      = (len < MIN_LEN) ? 0 : int'(len - MIN_LEN);
    cut_at = cut_in ? int'($urandom_range(n + 4)) : -1;
    line   = '{HDR_BYTE, HDR_BYTE, id, len, err};
    sum    = id + len + err;
    for (int i = 0; i < n; i++) begin
      b    = 8'($urandom);
      sum += b;
      line.push_back(b);
    end
    line.push_back(good_sum ? ~sum : 8'($urandom));
    foreach (line[i]) begin
      send_rx(line[i]);
      if (i == cut_at) send_random_cmd();
    end
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (ledger.pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned stop_at);
    int unsigned pick;
    int unsigned burst;
    logic [7:0]  len;
    while (words_sent < stop_at) begin
      pick = $urandom_range(9);
      if (pick <= 4) begin
        // mostly short packets, now and then a long parameter run
        len = ($urandom_range(15) == 0) ? 8'($urandom_range(48, 7)) : 8'($urandom_range(6));
        send_status_packet(8'($urandom), len,
                           $urandom_range(1) ? 8'd0 : 8'($urandom),
                           $urandom_range(9) != 0, $urandom_range(7) == 0);
      end else if (pick <= 7) begin
        send_random_cmd();
      end else if (pick == 8) begin
        send_rx(HDR_BYTE);
        send_rx(8'($urandom_range(254)));
      end else begin
        burst = $urandom_range(4, 1);
        repeat (burst) send_rx(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = KIND_RX_BYTE;
    words_sent    = 0;
    send_idle_pct = 23;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // field extremes and every command kind
    send_cmd(KIND_WRITE_WORD, 8'h00, 8'h00, 16'h0000);
    send_cmd(KIND_WRITE_WORD, 8'hFF, 8'hFF, 16'hFFFF);
    send_cmd(KIND_WRITE_BYTE, 8'h01, 8'h1E, 16'hA55A);
    send_cmd(KIND_READ_WORD, 8'hFE, 8'h24, 16'h1234);
    // clean status packet with two parameters
    send_status_packet(8'h01, 8'd4, 8'd0, 1'b1, 1'b0);
    // broken header drops back to hunting
    send_rx(HDR_BYTE);
    send_rx(8'h00);
    // short length, error set, bad checksum
    send_status_packet(8'hFF, 8'd1, 8'h80, 1'b0, 1'b0);
    // one parameter, command slipped in mid-packet
    send_status_packet(8'h05, 8'd3, 8'd0, 1'b1, 1'b1);

    random_traffic(ITEM_TARGET / 3);
    drain();
    send_idle_pct = 81;
    recv_idle_pct = 23;
    random_traffic(2 * ITEM_TARGET / 3);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(ITEM_TARGET);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ledger.pending_words.size() != 0)
      ledger.report_mismatch($sformatf("%0d words never arrived",
                                       ledger.pending_words.size()));
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
